// ===== rtl/fitsv_pkg.sv =====
package fitsv_pkg;

    localparam int VALUE_WIDTH       = 32;
    localparam int REP_COUNT_WIDTH   = 16;
    localparam int REPORTED          = 3;
    localparam int SLOTS_DEFAULT     = 3;
    localparam int COUNT_WIDTH_DEFAULT = 16;

    localparam int IN_DATA_WIDTH  = VALUE_WIDTH;
    localparam int OUT_DATA_WIDTH = REPORTED * (VALUE_WIDTH + REP_COUNT_WIDTH);

    // Carried from cell to cell: a lower slot already matched, or a lower slot is empty.
    typedef struct packed {
        logic hit;
        logic free;
    } chain_t;

endpackage

// ===== rtl/fitsv_cell.sv =====
module fitsv_cell #(
    parameter int COUNT_WIDTH = fitsv_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                take,
    input  logic                                clear,
    input  logic [fitsv_pkg::VALUE_WIDTH-1:0]   value,
    input  fitsv_pkg::chain_t                   chain_in,
    output fitsv_pkg::chain_t                   chain_out,
    input  logic                                hit_all,
    input  logic                                full_all,
    output logic [fitsv_pkg::VALUE_WIDTH-1:0]   value_next,
    output logic [COUNT_WIDTH-1:0]              count_next
);

    logic [fitsv_pkg::VALUE_WIDTH-1:0] value_reg;
    logic [COUNT_WIDTH-1:0]            count_reg;
    logic                              live;
    logic                              match;
    logic                              insert;

    assign live   = (count_reg != '0);
    assign match  = live && (value_reg == value);
    assign insert = !hit_all && !chain_in.free && !live;

    assign chain_out.hit  = chain_in.hit | match;
    assign chain_out.free = chain_in.free | !live;

    always_comb
    begin
        value_next = value_reg;
        count_next = count_reg;
        if (match)
        begin
            if (count_reg != '1)
            begin
                count_next = count_reg + COUNT_WIDTH'(1);
            end
        end
        else if (insert)
        begin
            value_next = value;
            count_next = COUNT_WIDTH'(1);
        end
        else if (!hit_all && full_all)
        begin
            // Every slot is live here, so the count is at least one.
            count_next = count_reg - COUNT_WIDTH'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
            count_reg <= '0;
        end
        else if (take)
        begin
            if (clear)
            begin
                value_reg <= '0;
                count_reg <= '0;
            end
            else
            begin
                value_reg <= value_next;
                count_reg <= count_next;
            end
        end
    end

endmodule

// ===== rtl/frequent_items_three_slot_vote.sv =====
// The result is registered: it appears in the cycle after the transfer that carries tlast.
// Throughput: one item per cycle; while a result waits on the output and is not
// taken, the input stalls until that result is taken.
// The per-item update is one ripple pass through the row of slot cells.
// Asynchronous reset (rst_n low) empties all slots and drops the result valid.
module frequent_items_three_slot_vote #(
    parameter int SLOTS       = fitsv_pkg::SLOTS_DEFAULT,
    parameter int COUNT_WIDTH = fitsv_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [fitsv_pkg::IN_DATA_WIDTH-1:0]   s_tdata,   // [31:0] value
    input  logic                                  s_tlast,   // last
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [31:0] candidate_a, [63:32] candidate_b, [95:64] candidate_c,
    // [111:96] count_a, [127:112] count_b, [143:128] count_c
    output logic [fitsv_pkg::OUT_DATA_WIDTH-1:0]  m_tdata
);

    localparam int VW = fitsv_pkg::VALUE_WIDTH;
    localparam int RW = fitsv_pkg::REP_COUNT_WIDTH;

    fitsv_pkg::chain_t     chain [SLOTS+1];
    logic [VW-1:0]         slot_value_next [SLOTS];
    logic [COUNT_WIDTH-1:0] slot_count_next [SLOTS];
    logic                  take;
    logic                  hit_all;
    logic                  full_all;
    logic [fitsv_pkg::OUT_DATA_WIDTH-1:0] result;

    logic                                 out_valid_reg;
    logic                                 out_valid_next;
    logic [fitsv_pkg::OUT_DATA_WIDTH-1:0] out_data_reg;

    assign s_tready = !out_valid_reg || m_tready;
    assign take     = s_tvalid && s_tready;

    assign chain[0].hit  = 1'b0;
    assign chain[0].free = 1'b0;
    assign hit_all  = chain[SLOTS].hit;
    assign full_all = !chain[SLOTS].free;

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        fitsv_cell #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .take       (take),
            .clear      (s_tlast),
            .value      (s_tdata[VW-1:0]),
            .chain_in   (chain[i]),
            .chain_out  (chain[i+1]),
            .hit_all    (hit_all),
            .full_all   (full_all),
            .value_next (slot_value_next[i]),
            .count_next (slot_count_next[i])
        );
    end

    for (genvar k = 0; k < fitsv_pkg::REPORTED; k++)
    begin : g_report
        if (k < SLOTS)
        begin : g_slot
            logic [32:0] count_ext;
            assign count_ext = 33'(slot_count_next[k]);
            assign result[k*VW +: VW] = slot_value_next[k];
            // Counts wider than the result field report as all ones.
            assign result[fitsv_pkg::REPORTED*VW + k*RW +: RW] =
                (count_ext > 33'(16'hFFFF)) ? {RW{1'b1}} : count_ext[RW-1:0];
        end
        else
        begin : g_none
            assign result[k*VW +: VW] = '0;
            assign result[fitsv_pkg::REPORTED*VW + k*RW +: RW] = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take && s_tlast)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && s_tlast)
        begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== rtl/fitsv_checker.sv =====
module fitsv_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 s_tvalid,
    input logic                                 s_tready,
    input logic                                 s_tlast,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [fitsv_pkg::OUT_DATA_WIDTH-1:0] m_tdata
);

    // A stalled result stays offered and unchanged.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    // The input side only waits on a result that is still pending.
    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output state");

    // Every transfer with tlast yields a result in the next cycle.
    a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> m_tvalid)
        else $error("no result after last transfer");

    // An item without tlast never produces a result.
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tlast |=> !m_tvalid)
        else $error("result without last transfer");

endmodule

bind frequent_items_three_slot_vote fitsv_checker u_fitsv_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== verif/tb_frequent_items_three_slot_vote.sv =====
`timescale 1ns / 100ps

module tb_frequent_items_three_slot_vote;

    localparam int VW = fitsv_pkg::VALUE_WIDTH;
    localparam int RW = fitsv_pkg::REP_COUNT_WIDTH;
    localparam int CW = fitsv_pkg::COUNT_WIDTH_DEFAULT;
    localparam int NS = fitsv_pkg::SLOTS_DEFAULT;
    localparam int NR = fitsv_pkg::REPORTED;

    localparam int LIMIT_CYCLES = 500_000;
    localparam int RANDOM_ITEMS = 1800;
    localparam int HOLD_CYCLES  = 300;
    localparam int LONG_RUN     = 40;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [CW-1:0] COUNT_TOP = '1;

    // Same layout as m_tdata: values in the low 96 bits, slot zero lowest.
    typedef struct packed {
        logic [NR-1:0][RW-1:0] counts;
        logic [NR-1:0][VW-1:0] values;
    } tally_t;

    typedef struct {
        logic [VW-1:0] value;
        logic          last;
        int unsigned   reps;
        bit            typed;
        tally_t        want;
    } row_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n;
    logic                                 s_tvalid;
    logic                                 s_tready;
    logic [fitsv_pkg::IN_DATA_WIDTH-1:0]  s_tdata;    // [31:0] value
    logic                                 s_tlast;    // last
    logic                                 m_tvalid;
    logic                                 m_tready;
    // [31:0] candidate_a, [63:32] candidate_b, [95:64] candidate_c,
    // [111:96] count_a, [127:112] count_b, [143:128] count_c
    logic [fitsv_pkg::OUT_DATA_WIDTH-1:0] m_tdata;

    logic [VW-1:0] slot_val [NS];
    logic [CW-1:0] slot_cnt [NS];

    tally_t      tally_due[$];
    int unsigned errors = 0;
    int unsigned cycles = 0;
    int unsigned sender_items = 0;
    int unsigned results_taken = 0;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;

    frequent_items_three_slot_vote dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, tally_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic tally_t tally(input logic [VW-1:0] va,
                                     input logic [RW-1:0] ca,
                                     input logic [VW-1:0] vb,
                                     input logic [RW-1:0] cb,
                                     input logic [VW-1:0] vc,
                                     input logic [RW-1:0] cc);
        tally_t t;
        t.values = {vc, vb, va};
        t.counts = {cc, cb, ca};
        return t;
    endfunction

    // One fifty-item window out of every four runs with no idle cycles at all.
    function automatic int unsigned quiet_gap(input int unsigned n);
        return ((n / 50) % 4 == 0) ? 0 : $urandom_range(0, 16);
    endfunction

    function automatic void absorb_value(input logic [VW-1:0] v);
        bit hit;
        bit placed;
        hit = 1'b0;
        placed = 1'b0;
        for (int i = 0; i < NS; i++)
        begin
            if (slot_cnt[i] != 0 && slot_val[i] == v)
            begin
                if (slot_cnt[i] != COUNT_TOP)
                    slot_cnt[i]++;
                hit = 1'b1;
            end
        end
        for (int i = 0; i < NS; i++)
        begin
            if (!hit && !placed && slot_cnt[i] == 0)
            begin
                slot_val[i] = v;
                slot_cnt[i] = CW'(1);
                placed = 1'b1;
            end
        end
        // Only reached with every slot live, so nothing wraps below zero.
        if (!hit && !placed)
        begin
            for (int i = 0; i < NS; i++)
                slot_cnt[i]--;
        end
    endfunction

    task automatic offer(input logic [VW-1:0] v, input logic lst,
                         input int unsigned gap, input bit typed, input tally_t want);
        tally_t snap;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= lst;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        absorb_value(v);
        if (lst)
        begin
            for (int k = 0; k < NR; k++)
            begin
                snap.values[k] = slot_val[k];
                snap.counts[k] = slot_cnt[k];
            end
            tally_due.push_back(typed ? want : snap);
            for (int k = 0; k < NS; k++)
            begin
                slot_val[k] = '0;
                slot_cnt[k] = '0;
            end
        end
        sender_items++;
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        tally_t got;
        tally_t due;
        if (m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (tally_due.size() == 0)
            begin
                errors++;
                $display("%0t: result %h arrived with none expected", $time, got);
            end
            else
            begin
                due = tally_due.pop_front();
                for (int k = 0; k < NR; k++)
                begin
                    if (got.values[k] !== due.values[k])
                    begin
                        errors++;
                        $display("%0t: slot %0d value expected %h, got %h",
                                 $time, k, due.values[k], got.values[k]);
                    end
                    if (got.counts[k] !== due.counts[k])
                    begin
                        errors++;
                        $display("%0t: slot %0d count expected %0d, got %0d",
                                 $time, k, due.counts[k], got.counts[k]);
                    end
                end
            end
        end
    end

    // Result side; one long hold-off lets results back up into the input.
    initial
    begin
        int unsigned gap;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                gap = quiet_gap(results_taken);
                if (gap > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            results_taken++;
            @(negedge clk);
        end
    end

    initial
    begin
        row_t          plan[$];
        logic [VW-1:0] pool[6];
        logic [VW-1:0] v;
        int unsigned   npool;
        int unsigned   len;
        int unsigned   sent;
        bit            burst;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        for (int k = 0; k < NS; k++)
        begin
            slot_val[k] = '0;
            slot_cnt[k] = '0;
        end

        plan.push_back('{32'h0000_0000, 1'b1, 1, 1'b1,
                         tally(32'h0, 16'd1, 32'h0, 16'd0, 32'h0, 16'd0)});
        plan.push_back('{32'h7fff_ffff, 1'b0, 1, 1'b0, '0});
        plan.push_back('{32'h8000_0000, 1'b0, 1, 1'b0, '0});
        plan.push_back('{32'hffff_ffff, 1'b0, 1, 1'b0, '0});
        plan.push_back('{32'h7fff_ffff, 1'b0, 1, 1'b0, '0});
        // A miss with all slots live takes one off every count.
        plan.push_back('{32'h1234_5678, 1'b0, 1, 1'b0, '0});
        plan.push_back('{32'h55aa_55aa, 1'b1, 1, 1'b1,
                         tally(32'h7fff_ffff, 16'd1, 32'h55aa_55aa, 16'd1,
                               32'hffff_ffff, 16'd0)});
        plan.push_back('{32'h0000_0005, 1'b0, 1, 1'b0, '0});
        plan.push_back('{32'h0000_0005, 1'b0, 1, 1'b0, '0});
        plan.push_back('{32'h0000_0006, 1'b0, 1, 1'b0, '0});
        plan.push_back('{32'h0000_0007, 1'b0, 1, 1'b0, '0});
        plan.push_back('{32'h0000_0008, 1'b0, 1, 1'b0, '0});
        // Dead slots still hold these values; they must be refilled, not matched.
        plan.push_back('{32'h0000_0006, 1'b0, 1, 1'b0, '0});
        plan.push_back('{32'h0000_0007, 1'b1, 1, 1'b0, '0});
        // A run of one value keeps counting up in a single slot.
        plan.push_back('{32'hdead_beef, 1'b1, LONG_RUN, 1'b1,
                         tally(32'hdead_beef, RW'(LONG_RUN), 32'h0, 16'd0,
                               32'h0, 16'd0)});
        plan.push_back('{32'h0000_0001, 1'b0, 1, 1'b0, '0});
        plan.push_back('{32'h0000_0002, 1'b0, 1, 1'b0, '0});
        plan.push_back('{32'h0000_0003, 1'b0, 1, 1'b0, '0});
        plan.push_back('{32'h0000_0004, 1'b1, 1, 1'b1,
                         tally(32'h1, 16'd0, 32'h2, 16'd0, 32'h3, 16'd0)});
        plan.push_back('{32'h8000_0000, 1'b1, 1, 1'b1,
                         tally(32'h8000_0000, 16'd1, 32'h0, 16'd0, 32'h0, 16'd0)});

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[r])
        begin
            for (int unsigned n = 0; n < plan[r].reps; n++)
                offer(plan[r].value, plan[r].last && (n == plan[r].reps - 1),
                      (plan[r].reps > 1) ? 0 : quiet_gap(sender_items),
                      plan[r].typed, plan[r].want);
        end

        // Short streams back to back while the result side is held off.
        hold_req = 1'b1;
        for (int i = 0; i < 24; i++)
            offer($urandom, i[0] || (i == 23), 0, 1'b0, '0);

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            npool = $urandom_range(1, 6);
            foreach (pool[j])
                pool[j] = ($urandom_range(0, 7) == 0) ?
                          ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff) : $urandom;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 24);
            burst = ($urandom_range(0, 3) == 0);
            for (int unsigned i = 0; i < len; i++)
            begin
                // Nine in ten transfers draw from the pool, half of those the first pool value; the rest are random.
                if ($urandom_range(0, 9) == 0)
                    v = $urandom;
                else if ($urandom_range(0, 1) == 1)
                    v = pool[0];
                else
                    v = pool[$urandom_range(0, npool - 1)];
                offer(v, i == len - 1, burst ? 0 : quiet_gap(sender_items), 1'b0, '0);
                sent++;
            end
        end
        s_tvalid <= 1'b0;

        while (tally_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== frequent_items_three_slot_vote.f =====
rtl/fitsv_pkg.sv
rtl/fitsv_cell.sv
rtl/frequent_items_three_slot_vote.sv
rtl/fitsv_checker.sv
verif/tb_frequent_items_three_slot_vote.sv
